// ===== design/complex_arithmetic_unit_core_macros.svh =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shared assertion helpers for the complex arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CAU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define CAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Command codes and pipeline control types.
// ----------------------------------------------------------------------------
package cau_pkg;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    // Control that travels through the pipeline beside the data.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
        logic dbz;
    } ctl_t;

endpackage

// ===== design/cau_sat.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit saturation
// Clips one signed wide value to the part range.
// ----------------------------------------------------------------------------
module cau_sat #(
    parameter int IN_W   = 40,
    parameter int PART_W = 16
) (
    input  logic signed [IN_W-1:0]   value,
    output logic signed [PART_W-1:0] result,
    output logic                     clip
);
    localparam logic signed [IN_W-1:0] MAX_V =
        IN_W'(signed'({1'b0, {(PART_W-1){1'b1}}}));
    localparam logic signed [IN_W-1:0] MIN_V =
        IN_W'(signed'({1'b1, {(PART_W-1){1'b0}}}));

    always_comb
    begin
        if (value > MAX_V)
        begin
            result = {1'b0, {(PART_W-1){1'b1}}};
            clip   = 1'b1;
        end
        else if (value < MIN_V)
        begin
            result = {1'b1, {(PART_W-1){1'b0}}};
            clip   = 1'b1;
        end
        else
        begin
            result = value[PART_W-1:0];
            clip   = 1'b0;
        end
    end
endmodule

// ===== design/cau_divider.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider
// Pipelined restoring divider, one quotient bit per stage, with stall.
// ----------------------------------------------------------------------------
module cau_divider #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 33,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [NUM_W-1:0]  quot,
    output logic [SIDE_W-1:0] side_out
);
    localparam int R_W = DEN_W + 1;

    logic              v_reg    [1:NUM_W];
    logic [NUM_W-1:0]  q_reg    [1:NUM_W];
    logic [R_W-1:0]    r_reg    [1:NUM_W];
    logic [DEN_W-1:0]  d_reg    [1:NUM_W];
    logic [SIDE_W-1:0] s_reg    [1:NUM_W];

    // Stage k shifts the next numerator bit into the remainder and
    // subtracts the divisor when it fits; quotient bits replace numerator
    // bits from the bottom of q.
    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic              v_in;
        logic [NUM_W-1:0]  q_in;
        logic [R_W-1:0]    r_in;
        logic [DEN_W-1:0]  d_in;
        logic [SIDE_W-1:0] s_in;
        logic [R_W:0]      trial;
        logic [R_W:0]      shifted;

        if (k == 0)
        begin : g_first
            assign v_in = in_valid;
            assign q_in = num;
            assign r_in = '0;
            assign d_in = den;
            assign s_in = side_in;
        end
        else
        begin : g_next
            assign v_in = v_reg[k];
            assign q_in = q_reg[k];
            assign r_in = r_reg[k];
            assign d_in = d_reg[k];
            assign s_in = s_reg[k];
        end

        assign shifted = {r_in, q_in[NUM_W-1]};
        assign trial   = shifted - {2'b00, d_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k+1] <= d_in;
                s_reg[k+1] <= s_in;
                if (!trial[R_W])
                begin
                    r_reg[k+1] <= trial[R_W-1:0];
                    q_reg[k+1] <= {q_in[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    r_reg[k+1] <= shifted[R_W-1:0];
                    q_reg[k+1] <= {q_in[NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[NUM_W];
    assign quot      = q_reg[NUM_W];
    assign side_out  = s_reg[NUM_W];
endmodule

// ===== design/complex_arithmetic_unit_core.sv =====
// A result item passes the operand, product, sum, divider-stage and output
// registers after its input item is accepted, the same path for every command.
// Throughput: one item per cycle while the result is not stalled; the bit-per-stage divider sets the depth.
// A stalled result freezes the whole pipeline and the input with it.
// Reset: asynchronous, active low; clears all valid bits, the pipeline drains.
// ----------------------------------------------------------------------------
// Complex arithmetic unit core
// Add, subtract, multiply and divide of signed fixed-point complex numbers.
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_core_macros.svh"

module complex_arithmetic_unit_core #(
    parameter int PART_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // command, a_real, a_imag, b_real, b_imag from the lowest bit up
    input  logic [((4*PART_WIDTH+2+7)/8)*8-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // res_real, res_imag, saturated, div_by_zero from the lowest bit up
    output logic [((2*PART_WIDTH+2+7)/8)*8-1:0] m_tdata
);
    import cau_pkg::*;

    localparam int P    = PART_WIDTH;
    localparam int PW   = 2 * P + 1;            // products, squares and plain sums
    localparam int DW   = 2 * P + 1;            // squared magnitude
    localparam int NW   = PW + FRAC_BITS;       // scaled numerator magnitude
    localparam int WW   = NW + 2;               // signed wide result
    localparam int OUTW = ((2*P+2+7)/8)*8;
    localparam int SIDE = 2 + 2 + WW + WW + 1;  // cmd, signs, plain re/im, dbz

    logic en;

    // ---------------- stage 1: register operands
    logic               v1_reg;
    cmd_t               c1_reg;
    logic signed [P-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg  <= cmd_t'(s_tdata[1:0]);
            ar1_reg <= s_tdata[2 +: P];
            ai1_reg <= s_tdata[2+P +: P];
            br1_reg <= s_tdata[2+2*P +: P];
            bi1_reg <= s_tdata[2+3*P +: P];
        end
    end

    // ---------------- stage 2: four products, two squares and the plain sums
    logic                v2_reg;
    cmd_t                c2_reg;
    logic signed [PW-1:0] pbr_reg, pbi_reg, qbr_reg, qbi_reg, dd1_reg, dd2_reg;
    logic signed [PW-1:0] sre_reg, sim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_reg  <= c1_reg;
            pbr_reg <= PW'(ar1_reg * br1_reg);
            pbi_reg <= PW'(ai1_reg * bi1_reg);
            qbr_reg <= PW'(ai1_reg * br1_reg);
            qbi_reg <= PW'(ar1_reg * bi1_reg);
            dd1_reg <= PW'(br1_reg * br1_reg);
            dd2_reg <= PW'(bi1_reg * bi1_reg);
            if (c1_reg == CMD_SUB)
            begin
                sre_reg <= PW'(ar1_reg) - PW'(br1_reg);
                sim_reg <= PW'(ai1_reg) - PW'(bi1_reg);
            end
            else
            begin
                sre_reg <= PW'(ar1_reg) + PW'(br1_reg);
                sim_reg <= PW'(ai1_reg) + PW'(bi1_reg);
            end
        end
    end

    // ---------------- stage 3: sums, signs, magnitudes
    logic signed [PW:0] re_s, im_s;
    logic [DW:0]        den_s;
    logic [WW-1:0]      plain_re, plain_im;
    logic               neg_re, neg_im, dbz;
    logic [NW-1:0]      mag_re, mag_im;

    always_comb
    begin
        den_s = (DW+1)'(unsigned'(dd1_reg)) + (DW+1)'(unsigned'(dd2_reg));
        dbz   = (c2_reg == CMD_DIV) && (den_s == '0);
        unique case (c2_reg)
            CMD_MUL:
            begin
                re_s = (PW+1)'(pbr_reg) - (PW+1)'(pbi_reg);
                im_s = (PW+1)'(qbi_reg) + (PW+1)'(qbr_reg);
            end
            CMD_DIV:
            begin
                re_s = (PW+1)'(pbr_reg) + (PW+1)'(pbi_reg);
                im_s = (PW+1)'(qbr_reg) - (PW+1)'(qbi_reg);
            end
            default:
            begin
                re_s = (PW+1)'(sre_reg);
                im_s = (PW+1)'(sim_reg);
            end
        endcase
        if (c2_reg == CMD_MUL)
        begin
            plain_re = WW'(re_s >>> FRAC_BITS);
            plain_im = WW'(im_s >>> FRAC_BITS);
        end
        else
        begin
            plain_re = WW'(re_s);
            plain_im = WW'(im_s);
        end
        neg_re = re_s[PW];
        neg_im = im_s[PW];
        mag_re = NW'(neg_re ? -re_s : re_s) << FRAC_BITS;
        mag_im = NW'(neg_im ? -im_s : im_s) << FRAC_BITS;
    end

    logic              v3_reg;
    logic [NW-1:0]     nre_reg, nim_reg;
    logic [DW-1:0]     den_reg;
    logic [SIDE-1:0]   side3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nre_reg   <= mag_re;
            nim_reg   <= mag_im;
            // A zero divisor is replaced by one so the divider stays defined.
            den_reg   <= (den_s == '0) ? DW'(1) : den_s[DW-1:0];
            side3_reg <= {dbz, plain_im, plain_re, neg_im, neg_re, c2_reg};
        end
    end

    // ---------------- divider lanes
    logic            dv_re, dv_im;
    logic [NW-1:0]   q_re, q_im;
    logic [SIDE-1:0] side_d, side_unused;

    cau_divider #(.NUM_W(NW), .DEN_W(DW), .SIDE_W(SIDE)) u_div_re (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v3_reg),
        .num(nre_reg), .den(den_reg), .side_in(side3_reg),
        .out_valid(dv_re), .quot(q_re), .side_out(side_d));

    cau_divider #(.NUM_W(NW), .DEN_W(DW), .SIDE_W(SIDE)) u_div_im (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v3_reg),
        .num(nim_reg), .den(den_reg), .side_in(side3_reg),
        .out_valid(dv_im), .quot(q_im), .side_out(side_unused));

    // ---------------- final: pick, saturate
    cmd_t          fc;
    logic          fneg_re, fneg_im, fdbz;
    logic [WW-1:0] fpl_re, fpl_im;
    logic signed [WW-1:0] val_re, val_im;
    logic signed [P-1:0]  sat_re, sat_im;
    logic          clip_re, clip_im;

    always_comb
    begin
        {fdbz, fpl_im, fpl_re, fneg_im, fneg_re, fc} = side_d;
        if (fc == CMD_DIV)
        begin
            val_re = fneg_re ? -signed'(WW'(q_re)) : signed'(WW'(q_re));
            val_im = fneg_im ? -signed'(WW'(q_im)) : signed'(WW'(q_im));
        end
        else
        begin
            val_re = signed'(fpl_re);
            val_im = signed'(fpl_im);
        end
    end

    cau_sat #(.IN_W(WW), .PART_W(P)) u_sat_re (.value(val_re), .result(sat_re), .clip(clip_re));
    cau_sat #(.IN_W(WW), .PART_W(P)) u_sat_im (.value(val_im), .result(sat_im), .clip(clip_im));

    logic            ov_reg;
    logic [OUTW-1:0] od_reg;

    // Whole pipeline advances when the output register is free or taken.
    assign en       = !ov_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= dv_re;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (fdbz)
                od_reg <= OUTW'({1'b1, 1'b0, {(2*P){1'b0}}});
            else
                od_reg <= OUTW'({1'b0, clip_re | clip_im, sat_im, sat_re});
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;

    `CAU_ASSERT_IMPL(a_lanes_agree, clk, rst_n, 1'b1, dv_re == dv_im, "divider lanes out of step")
    `CAU_ASSERT_IMPL(a_dbz_zero, clk, rst_n, m_tvalid && m_tdata[2*P+1], m_tdata[2*P:0] == '0, "zero divisor result not clean")
    `CAU_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
endmodule
